@@ rtl/l3d_pkg.sv @@
// Shared definitions for the 3D colour lookup table: command codes, field widths
// and the metadata record that travels beside the corner reads.
// No dependencies.
`timescale 1ns / 1ps

package l3d_pkg;

    localparam logic [1:0] CMD_APPLY = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam int FRAC_BITS = 12;
    localparam int PIX_W     = 13;
    localparam logic [PIX_W-1:0] ONE_Q = 13'd4096;
    localparam int CRD_W     = 6;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int GS_W      = 5;
    localparam int GRID_SIZE_RESET = 17;

    // Register index as seen in paddr[2].
    localparam logic REG_GRID_SIZE = 1'b0;

    typedef struct packed {
        logic                 valid;
        logic                 bad;
        logic [FRAC_BITS-1:0] fr;
        logic [FRAC_BITS-1:0] fg;
        logic [FRAC_BITS-1:0] fb;
        logic [2:0]           par;
    } t_meta;

endpackage

@@ rtl/l3d_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module l3d_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 729
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/l3d_fill.sv @@
// Identity ramp fill engine: a restoring divider for 4096/(n-1), then a sweep over
// every bank address writing all eight banks at once. Depends on l3d_pkg.
`timescale 1ns / 1ps

module l3d_fill #(
    parameter int GRID_MAX   = 17,
    parameter int VALUE_BITS = 16,
    localparam int NW = $clog2(GRID_MAX + 1),
    localparam int DW = $clog2(GRID_MAX),
    localparam int H  = GRID_MAX / 2 + 1,
    localparam int HW = $clog2(H),
    localparam int AW = $clog2(H * H * H),
    localparam int VB = VALUE_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NW-1:0]   i_n,
    output logic            o_busy,
    output logic            o_we,
    output logic [AW-1:0]   o_addr,
    output logic [3*VB-1:0] o_data [8]
);

    localparam int QW   = $clog2(2 * H * 4096 + 1) + 1;
    localparam int MAXV = (1 << (VB - 1)) - 1;
    localparam int PW   = l3d_pkg::PIX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_PREP  = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    logic [1:0]    r_state;
    logic [3:0]    r_cnt;
    logic [DW-1:0] r_rem;
    logic [PW-1:0] r_quo;
    logic [QW-1:0] r_q2, r_q1;
    logic [DW-1:0] r_r2, r_m1;
    logic [HW-1:0] r_ra, r_ga, r_ba;
    logic [AW-1:0] r_addr;
    logic [QW-1:0] r_gq [3][2];
    logic [DW-1:0] r_gm [3][2];

    logic [DW-1:0] d, h;
    logic [DW:0]   div_t;
    logic          div_ge;
    logic [DW:0]   r2s, m1s;
    logic [QW-1:0] n_gq [3][2];
    logic [DW-1:0] n_gm [3][2];
    logic [DW:0]   stp;

    assign d      = DW'(i_n - 1'b1);
    assign h      = d >> 1;
    assign div_t  = {r_rem, (r_cnt == 4'd12)};
    assign div_ge = div_t >= {1'b0, d};
    assign r2s    = {r_rem, 1'b0};
    assign m1s    = {1'b0, h} + {1'b0, r_rem};

    // Next value of every generator after one step of two grid points.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int p = 0; p < 2; p++) begin
                stp = {1'b0, r_gm[a][p]} + {1'b0, r_r2};
                if (stp >= {1'b0, d}) begin
                    n_gm[a][p] = DW'(stp - {1'b0, d});
                    n_gq[a][p] = r_gq[a][p] + r_q2 + 1'b1;
                end else begin
                    n_gm[a][p] = DW'(stp);
                    n_gq[a][p] = r_gq[a][p] + r_q2;
                end
            end
        end
    end

    function automatic logic [VB-1:0] sat_ramp(input logic [QW-1:0] q);
        if (int'(q) > MAXV) begin
            return VB'(MAXV);
        end
        return VB'(q);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DIV;
            r_cnt   <= 4'd12;
            r_rem   <= '0;
            r_quo   <= '0;
        end else if (i_start) begin
            r_state <= S_DIV;
            r_cnt   <= 4'd12;
            r_rem   <= '0;
            r_quo   <= '0;
        end else begin
            unique case (r_state)
                S_DIV: begin
                    r_rem <= div_ge ? DW'(div_t - {1'b0, d}) : DW'(div_t);
                    r_quo <= {r_quo[PW-2:0], div_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 4'd0) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r2s >= {1'b0, d}) begin
                        r_r2 <= DW'(r2s - {1'b0, d});
                        r_q2 <= QW'({r_quo, 1'b1});
                    end else begin
                        r_r2 <= DW'(r2s);
                        r_q2 <= QW'({r_quo, 1'b0});
                    end
                    for (int a = 0; a < 3; a++) begin
                        r_gq[a][0] <= '0;
                        r_gm[a][0] <= h;
                        if (m1s >= {1'b0, d}) begin
                            r_gq[a][1] <= QW'(r_quo) + 1'b1;
                            r_gm[a][1] <= DW'(m1s - {1'b0, d});
                        end else begin
                            r_gq[a][1] <= QW'(r_quo);
                            r_gm[a][1] <= DW'(m1s);
                        end
                    end
                    if (m1s >= {1'b0, d}) begin
                        r_q1 <= QW'(r_quo) + 1'b1;
                        r_m1 <= DW'(m1s - {1'b0, d});
                    end else begin
                        r_q1 <= QW'(r_quo);
                        r_m1 <= DW'(m1s);
                    end
                    r_ra    <= '0;
                    r_ga    <= '0;
                    r_ba    <= '0;
                    r_addr  <= '0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_ba != HW'(H - 1)) begin
                        r_ba    <= r_ba + 1'b1;
                        r_gq[2] <= n_gq[2];
                        r_gm[2] <= n_gm[2];
                    end else begin
                        r_ba       <= '0;
                        r_gq[2][0] <= '0;
                        r_gm[2][0] <= h;
                        r_gq[2][1] <= r_q1;
                        r_gm[2][1] <= r_m1;
                        if (r_ga != HW'(H - 1)) begin
                            r_ga    <= r_ga + 1'b1;
                            r_gq[1] <= n_gq[1];
                            r_gm[1] <= n_gm[1];
                        end else begin
                            r_ga       <= '0;
                            r_gq[1][0] <= '0;
                            r_gm[1][0] <= h;
                            r_gq[1][1] <= r_q1;
                            r_gm[1][1] <= r_m1;
                            r_ra       <= r_ra + 1'b1;
                            r_gq[0]    <= n_gq[0];
                            r_gm[0]    <= n_gm[0];
                            if (r_ra == HW'(H - 1)) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = r_state != S_IDLE;
    assign o_we   = r_state == S_SWEEP;
    assign o_addr = r_addr;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            o_data[k] = {sat_ramp(r_gq[0][(k >> 2) & 1]),
                         sat_ramp(r_gq[1][(k >> 1) & 1]),
                         sat_ramp(r_gq[2][k & 1])};
        end
    end

endmodule

@@ rtl/l3d_front.sv @@
// Front end of the pipeline: command decode, pixel scaling onto the grid,
// corner selection and bank addressing for reads and writes. Depends on l3d_pkg.
`timescale 1ns / 1ps

module l3d_front #(
    parameter int GRID_MAX   = 17,
    parameter int VALUE_BITS = 16,
    localparam int NW = $clog2(GRID_MAX + 1),
    localparam int H  = GRID_MAX / 2 + 1,
    localparam int AW = $clog2(H * H * H),
    localparam int VB = VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [1:0]                      i_command,
    input  logic [l3d_pkg::PIX_W-1:0]       i_in_red,
    input  logic [l3d_pkg::PIX_W-1:0]       i_in_green,
    input  logic [l3d_pkg::PIX_W-1:0]       i_in_blue,
    input  logic [l3d_pkg::CRD_W-1:0]       i_grid_r,
    input  logic [l3d_pkg::CRD_W-1:0]       i_grid_g,
    input  logic [l3d_pkg::CRD_W-1:0]       i_grid_b,
    input  logic signed [l3d_pkg::IN_W-1:0] i_new_red,
    input  logic signed [l3d_pkg::IN_W-1:0] i_new_green,
    input  logic signed [l3d_pkg::IN_W-1:0] i_new_blue,
    input  logic [NW-1:0]                   i_n,
    output logic [AW-1:0]                   o_raddr [8],
    output logic [7:0]                      o_we,
    output logic [AW-1:0]                   o_waddr,
    output logic [3*VB-1:0]                 o_wdata,
    output l3d_pkg::t_meta                  o_meta
);

    localparam int DW   = $clog2(GRID_MAX);
    localparam int IW   = NW;
    localparam int FB   = l3d_pkg::FRAC_BITS;
    localparam int PW   = l3d_pkg::PIX_W + DW;
    localparam int CW   = (NW > l3d_pkg::CRD_W) ? NW : l3d_pkg::CRD_W;
    localparam int MAXV = (1 << (VB - 1)) - 1;

    logic                 r_a_valid;
    logic [1:0]           r_a_cmd;
    logic [PW-1:0]        r_a_pos [3];
    logic [IW-1:0]        r_a_crd [3];
    logic                 r_a_in;
    logic signed [VB-1:0] r_a_new [3];
    l3d_pkg::t_meta       r_meta;

    logic [DW-1:0]        d;
    logic [l3d_pkg::PIX_W-1:0] pix [3];
    logic [CW-1:0]        crd [3];
    logic                 in_grid;
    logic [DW:0]          i0;
    logic [IW-1:0]        lo [3];
    logic [IW-1:0]        hi [3];
    logic [FB-1:0]        fr [3];
    logic [IW-1:0]        cc [3];
    logic [2:0]           wbank;

    function automatic logic signed [VB-1:0] sat_in(input logic signed [15:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        if (w > MAXV) begin
            return VB'(MAXV);
        end
        if (w < -MAXV - 1) begin
            return VB'(-MAXV - 1);
        end
        return w[VB-1:0];
    endfunction

    function automatic logic [l3d_pkg::PIX_W-1:0] sat_pix(input logic [l3d_pkg::PIX_W-1:0] c);
        return (c > l3d_pkg::ONE_Q) ? l3d_pkg::ONE_Q : c;
    endfunction

    assign d = DW'(i_n - 1'b1);
    assign pix[0] = sat_pix(i_in_red);
    assign pix[1] = sat_pix(i_in_green);
    assign pix[2] = sat_pix(i_in_blue);
    assign crd[0] = CW'(i_grid_r);
    assign crd[1] = CW'(i_grid_g);
    assign crd[2] = CW'(i_grid_b);
    assign in_grid = (crd[0] < CW'(i_n)) && (crd[1] < CW'(i_n)) && (crd[2] < CW'(i_n));

    // Stage A: scale each component by n-1 and register the decoded command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_accept;
        end
        if (i_accept) begin
            r_a_cmd <= i_command;
            r_a_in  <= in_grid;
            for (int a = 0; a < 3; a++) begin
                r_a_pos[a] <= PW'(pix[a]) * PW'(d);
                r_a_crd[a] <= in_grid ? crd[a][IW-1:0] : '0;
            end
            r_a_new[0] <= sat_in(i_new_red);
            r_a_new[1] <= sat_in(i_new_green);
            r_a_new[2] <= sat_in(i_new_blue);
        end
    end

    // Stage B: lower corner and weight per axis, then one address per bank.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            i0 = r_a_pos[a][PW-1:FB];
            if (r_a_cmd == l3d_pkg::CMD_APPLY) begin
                if (i0 >= (DW + 1)'(d)) begin
                    lo[a] = IW'(d);
                    fr[a] = '0;
                end else begin
                    lo[a] = IW'(i0);
                    fr[a] = r_a_pos[a][FB-1:0];
                end
            end else begin
                lo[a] = r_a_crd[a];
                fr[a] = '0;
            end
            hi[a] = lo[a] + 1'b1;
        end
        for (int k = 0; k < 8; k++) begin
            for (int a = 0; a < 3; a++) begin
                cc[a] = (lo[a][0] == k[2-a]) ? lo[a] : hi[a];
            end
            o_raddr[k] = AW'((int'(cc[0][IW-1:1]) * H + int'(cc[1][IW-1:1])) * H
                             + int'(cc[2][IW-1:1]));
        end
    end

    assign wbank   = {lo[0][0], lo[1][0], lo[2][0]};
    assign o_waddr = o_raddr[wbank];
    assign o_wdata = {r_a_new[0], r_a_new[1], r_a_new[2]};

    always_comb begin
        o_we = '0;
        if (r_a_valid && r_a_cmd == l3d_pkg::CMD_WRITE && r_a_in) begin
            o_we[wbank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.valid <= 1'b0;
        end else begin
            r_meta.valid <= r_a_valid && (r_a_cmd == l3d_pkg::CMD_APPLY ||
                                          r_a_cmd == l3d_pkg::CMD_READ);
        end
        r_meta.bad <= (r_a_cmd == l3d_pkg::CMD_READ) && !r_a_in;
        r_meta.fr  <= fr[0];
        r_meta.fg  <= fr[1];
        r_meta.fb  <= fr[2];
        r_meta.par <= wbank;
    end

    assign o_meta = r_meta;

endmodule

@@ rtl/l3d_blend.sv @@
// Trilinear blend pipeline: corner unscrambling, then blue, green and red lerps,
// each multiply registered, and output saturation. Depends on l3d_pkg.
`timescale 1ns / 1ps

module l3d_blend #(
    parameter int VALUE_BITS = 16,
    localparam int VB = VALUE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [3*VB-1:0]                  i_rdata [8],
    input  l3d_pkg::t_meta                   i_meta,
    output logic                             o_done,
    output logic signed [l3d_pkg::OUT_W-1:0] o_red,
    output logic signed [l3d_pkg::OUT_W-1:0] o_green,
    output logic signed [l3d_pkg::OUT_W-1:0] o_blue,
    output logic                             o_invalid
);

    localparam int FB  = l3d_pkg::FRAC_BITS;
    localparam int PRW = VB + 14;

    function automatic logic signed [PRW-1:0] lerp_mul(input logic signed [VB-1:0] a,
                                                     input logic signed [VB-1:0] b,
                                                     input logic [FB-1:0] t);
        logic signed [PRW-1:0] de, te;
        de = PRW'((VB + 1)'(b) - (VB + 1)'(a));
        te = PRW'(signed'({1'b0, t}));
        return de * te;
    endfunction

    function automatic logic signed [VB-1:0] lerp_add(input logic signed [VB-1:0] a,
                                                     input logic signed [PRW-1:0] p);
        logic signed [PRW-1:0] s;
        s = PRW'(a) + (p >>> FB);
        return s[VB-1:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [VB-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        if (w > 32'sd32767) begin
            return 16'sh7fff;
        end
        if (w < -32'sd32768) begin
            return 16'sh8000;
        end
        return w[15:0];
    endfunction

    logic signed [VB-1:0]  cv [3][8];
    logic signed [VB-1:0]  dv [3][4];
    logic signed [VB-1:0]  ev [3][2];
    logic signed [VB-1:0]  fv [3];

    l3d_pkg::t_meta        r_c_meta, r_d_meta, r_e_meta;
    logic signed [VB-1:0]  r_c_a [3][4];
    logic signed [PRW-1:0] r_c_p [3][4];
    logic signed [VB-1:0]  r_d_a [3][2];
    logic signed [PRW-1:0] r_d_p [3][2];
    logic signed [VB-1:0]  r_e_a [3];
    logic signed [PRW-1:0] r_e_p [3];
    logic                  r_done, r_invalid;
    logic signed [15:0]    r_out [3];

    // Corner j = {r, g, b offset}; it sits in the bank whose parity is j ^ par.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int j = 0; j < 8; j++) begin
                cv[ch][j] = i_rdata[3'(j) ^ i_meta.par][VB*(2-ch) +: VB];
            end
            for (int m = 0; m < 4; m++) begin
                dv[ch][m] = lerp_add(r_c_a[ch][m], r_c_p[ch][m]);
            end
            for (int m = 0; m < 2; m++) begin
                ev[ch][m] = lerp_add(r_d_a[ch][m], r_d_p[ch][m]);
            end
            fv[ch] = lerp_add(r_e_a[ch], r_e_p[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_meta.valid <= 1'b0;
            r_d_meta.valid <= 1'b0;
            r_e_meta.valid <= 1'b0;
            r_done         <= 1'b0;
        end else begin
            r_c_meta.valid <= i_meta.valid;
            r_d_meta.valid <= r_c_meta.valid;
            r_e_meta.valid <= r_d_meta.valid;
            r_done         <= r_e_meta.valid;
        end
        r_c_meta.bad <= i_meta.bad;
        r_c_meta.fr  <= i_meta.fr;
        r_c_meta.fg  <= i_meta.fg;
        r_c_meta.fb  <= i_meta.fb;
        r_c_meta.par <= i_meta.par;
        r_d_meta.bad <= r_c_meta.bad;
        r_d_meta.fr  <= r_c_meta.fr;
        r_d_meta.fg  <= r_c_meta.fg;
        r_d_meta.fb  <= r_c_meta.fb;
        r_d_meta.par <= r_c_meta.par;
        r_e_meta.bad <= r_d_meta.bad;
        r_e_meta.fr  <= r_d_meta.fr;
        r_e_meta.fg  <= r_d_meta.fg;
        r_e_meta.fb  <= r_d_meta.fb;
        r_e_meta.par <= r_d_meta.par;
        for (int ch = 0; ch < 3; ch++) begin
            for (int m = 0; m < 4; m++) begin
                r_c_a[ch][m] <= cv[ch][2*m];
                r_c_p[ch][m] <= lerp_mul(cv[ch][2*m], cv[ch][2*m+1], i_meta.fb);
            end
            for (int m = 0; m < 2; m++) begin
                r_d_a[ch][m] <= dv[ch][2*m];
                r_d_p[ch][m] <= lerp_mul(dv[ch][2*m], dv[ch][2*m+1], r_c_meta.fg);
            end
            r_e_a[ch] <= ev[ch][0];
            r_e_p[ch] <= lerp_mul(ev[ch][0], ev[ch][1], r_d_meta.fr);
            r_out[ch] <= r_e_meta.bad ? 16'sd0 : sat16(fv[ch]);
        end
        r_invalid <= r_e_meta.bad;
    end

    assign o_done    = r_done;
    assign o_red     = r_out[0];
    assign o_green   = r_out[1];
    assign o_blue    = r_out[2];
    assign o_invalid = r_invalid;

endmodule

@@ rtl/lut3d_trilinear_color_map.sv @@
// Top level of the 3D colour lookup table with trilinear interpolation.
// Depends on l3d_pkg, l3d_ram, l3d_fill, l3d_front and l3d_blend.
`timescale 1ns / 1ps

// Channel     Direction  Handshake                        Beat
// command     in         i_start high while o_busy low    command, pixel, coordinates, entry
// result      out        o_done for one cycle, no stall   three channels and coord_invalid
// config      in/out     APB write, psel penable pwrite   grid_size at byte address 0
//
// One command beat is taken in every clock cycle while o_busy is low. A result is
// registered in stage A, the bank reads, the blue, green and red lerps and the output
// stage, with no stall between; write commands and the unused command code give no result.
// The lookup store is split into eight banks by the parity of the red, green and blue
// coordinates, so the eight corners of a cell are read in the same cycle. After reset
// and after every grid_size write the store is refilled with the identity ramp (divider
// and setup, then a sweep over all (GRID_MAX/2+1)^3 bank addresses), during which o_busy
// is high. The receiver cannot stall, so results never back up.

module lut3d_trilinear_color_map #(
    parameter int GRID_MAX   = 17,
    parameter int VALUE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [1:0]                      i_command,
    input  logic [l3d_pkg::PIX_W-1:0]       i_in_red,
    input  logic [l3d_pkg::PIX_W-1:0]       i_in_green,
    input  logic [l3d_pkg::PIX_W-1:0]       i_in_blue,
    input  logic [l3d_pkg::CRD_W-1:0]       i_grid_r,
    input  logic [l3d_pkg::CRD_W-1:0]       i_grid_g,
    input  logic [l3d_pkg::CRD_W-1:0]       i_grid_b,
    input  logic signed [l3d_pkg::IN_W-1:0] i_new_red,
    input  logic signed [l3d_pkg::IN_W-1:0] i_new_green,
    input  logic signed [l3d_pkg::IN_W-1:0] i_new_blue,
    output logic                            o_done,
    output logic signed [l3d_pkg::OUT_W-1:0] o_out_red,
    output logic signed [l3d_pkg::OUT_W-1:0] o_out_green,
    output logic signed [l3d_pkg::OUT_W-1:0] o_out_blue,
    output logic                            o_coord_invalid,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int NW = $clog2(GRID_MAX + 1);
    localparam int H  = GRID_MAX / 2 + 1;
    localparam int AW = $clog2(H * H * H);
    localparam int VB = VALUE_BITS;
    localparam int RESET_N = (l3d_pkg::GRID_SIZE_RESET < GRID_MAX) ?
                             l3d_pkg::GRID_SIZE_RESET : GRID_MAX;

    logic [NW-1:0]   r_n;
    logic            cfg_wr;
    logic [l3d_pkg::GS_W-1:0] wr_size;
    logic [NW-1:0]   clamped;
    logic            accept;

    logic            fill_busy, fill_we;
    logic [AW-1:0]   fill_addr;
    logic [3*VB-1:0] fill_data [8];

    logic [AW-1:0]   raddr [8];
    logic [7:0]      fe_we;
    logic [AW-1:0]   fe_waddr;
    logic [3*VB-1:0] fe_wdata;
    l3d_pkg::t_meta  meta;
    logic [3*VB-1:0] rdata [8];

    // The grid size is clamped to the supported range as it is written.
    assign cfg_wr  = psel && penable && pwrite && pready &&
                     (paddr[2] == l3d_pkg::REG_GRID_SIZE);
    assign wr_size = pwdata[l3d_pkg::GS_W-1:0];

    always_comb begin
        if (wr_size < l3d_pkg::GS_W'(2)) begin
            clamped = NW'(2);
        end else if (int'(wr_size) > GRID_MAX) begin
            clamped = NW'(GRID_MAX);
        end else begin
            clamped = NW'(wr_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= NW'(RESET_N);
        end else if (cfg_wr) begin
            r_n <= clamped;
        end
    end

    assign prdata = 32'(r_n);
    assign pready = 1'b1;

    // Commands are refused only while the fill engine is busy with the identity ramp.
    assign o_busy = fill_busy;
    assign accept = i_start && !fill_busy;

    l3d_fill #(
        .GRID_MAX   (GRID_MAX),
        .VALUE_BITS (VALUE_BITS)
    ) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_wr),
        .i_n     (r_n),
        .o_busy  (fill_busy),
        .o_we    (fill_we),
        .o_addr  (fill_addr),
        .o_data  (fill_data)
    );

    l3d_front #(
        .GRID_MAX   (GRID_MAX),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_grid_r    (i_grid_r),
        .i_grid_g    (i_grid_g),
        .i_grid_b    (i_grid_b),
        .i_new_red   (i_new_red),
        .i_new_green (i_new_green),
        .i_new_blue  (i_new_blue),
        .i_n         (r_n),
        .o_raddr     (raddr),
        .o_we        (fe_we),
        .o_waddr     (fe_waddr),
        .o_wdata     (fe_wdata),
        .o_meta      (meta)
    );

    // Writes and corner reads are issued from the same stage, so a read always
    // sees every write from an earlier command.
    for (genvar k = 0; k < 8; k++) begin : g_bank
        l3d_ram #(
            .WIDTH (3 * VB),
            .DEPTH (H * H * H)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (fill_we || fe_we[k]),
            .i_waddr (fill_we ? fill_addr : fe_waddr),
            .i_wdata (fill_we ? fill_data[k] : fe_wdata),
            .i_raddr (raddr[k]),
            .o_rdata (rdata[k])
        );
    end

    l3d_blend #(
        .VALUE_BITS (VALUE_BITS)
    ) u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rdata   (rdata),
        .i_meta    (meta),
        .o_done    (o_done),
        .o_red     (o_out_red),
        .o_green   (o_out_green),
        .o_blue    (o_out_blue),
        .o_invalid (o_coord_invalid)
    );

endmodule

@@ verif/tb_lut3d_trilinear_color_map.sv @@
// Self-checking testbench for the 3D colour lookup table with trilinear blending.
// Depends on l3d_pkg and lut3d_trilinear_color_map; an in-bench predictor models the store.
`timescale 1ns / 1ps

// One result beat: three colour channels and the invalid-coordinate flag.
typedef struct packed {
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
    logic               bad;
} t_colour;

// Holds the colour beats that the block still owes and compares each result
// beat against the oldest of them.
class colour_scoreboard;
    t_colour owed_q[$];
    int      errors;
    int      checked;

    function void note_expected(t_colour c);
        owed_q.push_back(c);
    endfunction

    task report(string what);
        $display("MISMATCH: %s", what);
        errors++;
    endtask

    task check_result(t_colour got);
        t_colour want;
        if (owed_q.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        want = owed_q.pop_front();
        checked++;
        if (got.red !== want.red)
            report($sformatf("red got %0d want %0d", got.red, want.red));
        if (got.green !== want.green)
            report($sformatf("green got %0d want %0d", got.green, want.green));
        if (got.blue !== want.blue)
            report($sformatf("blue got %0d want %0d", got.blue, want.blue));
        if (got.bad !== want.bad)
            report($sformatf("coord_invalid got %0b want %0b", got.bad, want.bad));
    endtask
endclass

module tb_lut3d_trilinear_color_map;

    localparam int GMAX      = 17;
    localparam int DEPTH     = GMAX * GMAX * GMAX;
    // The limit allows many refills of the largest grid.
    localparam int CYCLE_CAP = 400000;
    // The one command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_command;
    logic [12:0] i_in_red, i_in_green, i_in_blue;
    logic [5:0]  i_grid_r, i_grid_g, i_grid_b;
    logic signed [15:0] i_new_red, i_new_green, i_new_blue;
    logic        o_done;
    logic signed [15:0] o_out_red, o_out_green, o_out_blue;
    logic        o_coord_invalid;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lut3d_trilinear_color_map u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_command(i_command), .i_in_red(i_in_red), .i_in_green(i_in_green),
        .i_in_blue(i_in_blue), .i_grid_r(i_grid_r), .i_grid_g(i_grid_g),
        .i_grid_b(i_grid_b), .i_new_red(i_new_red), .i_new_green(i_new_green),
        .i_new_blue(i_new_blue), .o_done(o_done), .o_out_red(o_out_red),
        .o_out_green(o_out_green), .o_out_blue(o_out_blue),
        .o_coord_invalid(o_coord_invalid), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    colour_scoreboard board;

    // The predictor's own copy of the store and of the grid size.
    int lut_mem [DEPTH][3];
    int grid_n;
    int cycles = 0;
    int beats_sent;
    int sizes_used;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Free-running cycle counter; it ends a run that has hung.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result beats cannot be held off, so every strobe is checked at the edge
    // that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            board.check_result({o_out_red, o_out_green, o_out_blue, o_coord_invalid});
    end

    function automatic int sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    // Arithmetic shift by the fraction width rounds towards minus infinity.
    function automatic longint mix(longint a, longint b, int t);
        return a + ((longint'(t) * (b - a)) >>> l3d_pkg::FRAC_BITS);
    endfunction

    function automatic void refill_ramp();
        int d;
        for (int k = 0; k < DEPTH; k++)
            for (int c = 0; c < 3; c++) lut_mem[k][c] = 0;
        d = grid_n - 1;
        for (int r = 0; r < grid_n; r++)
            for (int g = 0; g < grid_n; g++)
                for (int b = 0; b < grid_n; b++) begin
                    lut_mem[(r*grid_n+g)*grid_n+b][0] = sat16((r*4096 + d/2) / d);
                    lut_mem[(r*grid_n+g)*grid_n+b][1] = sat16((g*4096 + d/2) / d);
                    lut_mem[(r*grid_n+g)*grid_n+b][2] = sat16((b*4096 + d/2) / d);
                end
    endfunction

    function automatic void locate(int c, output int lo, output int hi, output int fr);
        int p;
        if (c > 4096) c = 4096;
        p  = c * (grid_n - 1);
        lo = p >> l3d_pkg::FRAC_BITS;
        fr = p & 4095;
        if (lo >= grid_n - 1) begin
            lo = grid_n - 1;
            fr = 0;
        end
        hi = (lo + 1 < grid_n) ? lo + 1 : grid_n - 1;
    endfunction

    // Works out what one accepted command beat does to the store and what it returns.
    function automatic void predict_colour(logic [1:0] cmd, int pr, int pg, int pb,
                                           int gr, int gg, int gb, int nr, int ng, int nb);
        t_colour res;
        int r0, r1, g0, g1, b0, b1, fr, fg, fb, n, idx;
        longint c00, c01, c10, c11;
        logic in_grid;
        n = grid_n;
        res = '0;
        if (cmd == l3d_pkg::CMD_APPLY) begin
            locate(pr, r0, r1, fr);
            locate(pg, g0, g1, fg);
            locate(pb, b0, b1, fb);
            for (int k = 0; k < 3; k++) begin
                c00 = mix(lut_mem[(r0*n+g0)*n+b0][k], lut_mem[(r0*n+g0)*n+b1][k], fb);
                c01 = mix(lut_mem[(r0*n+g1)*n+b0][k], lut_mem[(r0*n+g1)*n+b1][k], fb);
                c10 = mix(lut_mem[(r1*n+g0)*n+b0][k], lut_mem[(r1*n+g0)*n+b1][k], fb);
                c11 = mix(lut_mem[(r1*n+g1)*n+b0][k], lut_mem[(r1*n+g1)*n+b1][k], fb);
                c00 = mix(mix(c00, c01, fg), mix(c10, c11, fg), fr);
                case (k)
                    0: res.red   = 16'(sat16(c00));
                    1: res.green = 16'(sat16(c00));
                    default: res.blue = 16'(sat16(c00));
                endcase
            end
            board.note_expected(res);
        end else if (cmd == l3d_pkg::CMD_WRITE || cmd == l3d_pkg::CMD_READ) begin
            in_grid = (gr < n) && (gg < n) && (gb < n);
            idx = (gr*n + gg)*n + gb;
            if (cmd == l3d_pkg::CMD_WRITE) begin
                if (in_grid) begin
                    lut_mem[idx][0] = nr;
                    lut_mem[idx][1] = ng;
                    lut_mem[idx][2] = nb;
                end
            end else begin
                if (in_grid) begin
                    res.red   = 16'(lut_mem[idx][0]);
                    res.green = 16'(lut_mem[idx][1]);
                    res.blue  = 16'(lut_mem[idx][2]);
                end else begin
                    res.bad = 1'b1;
                end
                board.note_expected(res);
            end
        end
    endfunction

    // One command beat: held until taken at an edge with o_busy low.
    task automatic send_beat(logic [1:0] cmd, int pr, int pg, int pb, int gr, int gg,
                             int gb, int nr, int ng, int nb);
        i_start     <= 1'b1;
        i_command   <= cmd;
        i_in_red    <= 13'(pr);
        i_in_green  <= 13'(pg);
        i_in_blue   <= 13'(pb);
        i_grid_r    <= 6'(gr);
        i_grid_g    <= 6'(gg);
        i_grid_b    <= 6'(gb);
        i_new_red   <= 16'(nr);
        i_new_green <= 16'(ng);
        i_new_blue  <= 16'(nb);
        do @(posedge i_clk); while (o_busy);
        predict_colour(cmd, pr, pg, pb, gr, gg, gb,
                       int'($signed(16'(nr))), int'($signed(16'(ng))), int'($signed(16'(nb))));
        beats_sent++;
    endtask

    task automatic idle_gap(int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Lets every owed result arrive, then waits out the pipeline so that any
    // write still in flight has landed before the register changes.
    task automatic drain();
        i_start <= 1'b0;
        while (board.owed_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_grid_size(int value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {l3d_pkg::REG_GRID_SIZE, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        grid_n = (value < 2) ? 2 : (value > GMAX ? GMAX : value);
        refill_ramp();
        sizes_used++;
    endtask

    function automatic int rand_pix();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 4096;
            2: return $urandom_range(4097, 8191);
            default: return $urandom_range(0, 4096);
        endcase
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(0, 5) == 0) return $urandom_range(0, 63);
        return $urandom_range(0, grid_n - 1);
    endfunction

    // Random phase: a mix of applies, writes and reads at random pixels and coordinates,
    // with some unused codes and stray coordinates.
    task automatic random_phase(int count, bit with_gaps);
        int kind;
        for (int i = 0; i < count; i++) begin
            if (with_gaps && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 18));
            kind = $urandom_range(0, 9);
            if (kind < 4)
                send_beat(l3d_pkg::CMD_APPLY, rand_pix(), rand_pix(), rand_pix(),
                          0, 0, 0, 0, 0, 0);
            else if (kind < 7)
                send_beat(l3d_pkg::CMD_WRITE, 0, 0, 0, rand_coord(), rand_coord(),
                          rand_coord(), $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
            else if (kind < 9)
                send_beat(l3d_pkg::CMD_READ, 0, 0, 0, rand_coord(), rand_coord(),
                          rand_coord(), 0, 0, 0);
            else
                send_beat(CMD_UNUSED, $urandom_range(0, 8191), 0, 0, 0, 0, 0, 0, 0, 0);
        end
    endtask

    initial begin
        board = new();
        beats_sent = 0;
        sizes_used = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_command = l3d_pkg::CMD_APPLY;
        {i_in_red, i_in_green, i_in_blue} = '0;
        {i_grid_r, i_grid_g, i_grid_b} = '0;
        {i_new_red, i_new_green, i_new_blue} = '0;
        {psel, penable, pwrite} = 3'b000;
        paddr = '0;
        pwdata = '0;
        grid_n = l3d_pkg::GRID_SIZE_RESET;
        refill_ramp();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset grid: corners, saturation, full-range entries.
        send_beat(l3d_pkg::CMD_APPLY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(l3d_pkg::CMD_APPLY, 4096, 4096, 4096, 0, 0, 0, 0, 0, 0);
        send_beat(l3d_pkg::CMD_APPLY, 8191, 8191, 8191, 0, 0, 0, 0, 0, 0);
        send_beat(l3d_pkg::CMD_APPLY, 2048, 4095, 1, 0, 0, 0, 0, 0, 0);
        send_beat(l3d_pkg::CMD_WRITE, 0, 0, 0, 0, 0, 0, 32767, -32768, -1);
        send_beat(l3d_pkg::CMD_WRITE, 0, 0, 0, 0, 0, 1, -32768, 32767, 0);
        send_beat(l3d_pkg::CMD_WRITE, 0, 0, 0, 16, 16, 16, -32768, -32768, 32767);
        send_beat(l3d_pkg::CMD_WRITE, 0, 0, 0, 63, 63, 63, 1234, 1234, 1234);
        send_beat(l3d_pkg::CMD_WRITE, 0, 0, 0, 17, 0, 0, 1, 1, 1);
        send_beat(l3d_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(l3d_pkg::CMD_READ, 0, 0, 0, 16, 16, 16, 0, 0, 0);
        send_beat(l3d_pkg::CMD_READ, 0, 0, 0, 0, 17, 0, 0, 0, 0);
        send_beat(l3d_pkg::CMD_READ, 0, 0, 0, 63, 63, 63, 0, 0, 0);
        send_beat(l3d_pkg::CMD_APPLY, 128, 0, 128, 0, 0, 0, 0, 0, 0);
        send_beat(l3d_pkg::CMD_APPLY, 4096, 4096, 4000, 0, 0, 0, 0, 0, 0);
        send_beat(CMD_UNUSED, 8191, 8191, 8191, 63, 63, 63, -1, -1, -1);
        send_beat(l3d_pkg::CMD_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0);

        // Sizes below the minimum and above the maximum are clamped by the block.
        set_grid_size(0);
        send_beat(l3d_pkg::CMD_APPLY, 4096, 2048, 0, 0, 0, 0, 0, 0, 0);
        send_beat(l3d_pkg::CMD_READ, 0, 0, 0, 1, 1, 2, 0, 0, 0);
        random_phase(60, 1'b1);
        set_grid_size(31);
        random_phase(80, 1'b1);
        set_grid_size(3);
        random_phase(70, 1'b1);
        set_grid_size(2);
        random_phase(60, 1'b1);
        set_grid_size($urandom_range(4, 16));
        random_phase(90, 1'b1);
        set_grid_size(17);
        random_phase(70, 1'b0);

        drain();
        $display("Covered %0d command beats over %0d grid sizes; %0d results checked.",
                 beats_sent, sizes_used + 1, board.checked);
        if (board.errors == 0 && board.owed_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     board.errors, board.owed_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/l3d_pkg.sv
rtl/l3d_ram.sv
rtl/l3d_fill.sv
rtl/l3d_front.sv
rtl/l3d_blend.sv
rtl/lut3d_trilinear_color_map.sv
verif/tb_lut3d_trilinear_color_map.sv
